[src/mlfq_pkg.sv]
// ----------------------------------------------------------------------------
// mlfq_pkg: shared types, codes and helpers of the MLFQ scheduler
// Holds the slot record layout, command/state/status codes and small helpers.
// ----------------------------------------------------------------------------
package mlfq_pkg;

    localparam int NUM_SLOTS   = 64;
    localparam int SLOT_W      = $clog2(NUM_SLOTS);
    localparam int NUM_LEVELS  = 5;
    localparam int LEVEL_W     = 3;
    localparam int COUNT_WIDTH = 16;
    localparam int ID_W        = 32;
    localparam int CFG_W       = 40;
    localparam int KEY_W       = ID_W + 1;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_ALLOC = 2'd1;
    localparam logic [1:0] CMD_SET   = 2'd2;
    localparam logic [1:0] CMD_SCHED = 2'd3;

    localparam logic [2:0] ST_UNUSED   = 3'd0;
    localparam logic [2:0] ST_EMBRYO   = 3'd1;
    localparam logic [2:0] ST_SLEEPING = 3'd2;
    localparam logic [2:0] ST_RUNNABLE = 3'd3;
    localparam logic [2:0] ST_RUNNING  = 3'd4;
    localparam logic [2:0] ST_ZOMBIE   = 3'd5;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_NO_SLOT  = 2'd1;
    localparam logic [1:0] STAT_NONE_RUN = 2'd2;
    localparam logic [1:0] STAT_UNUSED   = 2'd3;

    localparam logic CFG_AGING = 1'b0;
    localparam logic CFG_SLICE = 1'b1;

    localparam logic [CFG_W-1:0] AGING_RESET = 40'd215422083865;
    localparam logic [CFG_W-1:0] SLICE_RESET = 40'd68853957121;

    typedef struct packed {
        logic [2:0]             state;
        logic [LEVEL_W-1:0]     level;
        logic [COUNT_WIDTH-1:0] slice;
        logic [COUNT_WIDTH-1:0] wait_cnt;
        logic [COUNT_WIDTH-1:0] io_wait;
        logic [ID_W-1:0]        entry;
        logic [ID_W-1:0]        id;
    } t_rec;

    typedef struct packed {
        logic              start;
        logic [1:0]        cmd;
        logic [2:0]        new_state;
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
        logic              proc;
        logic [SLOT_W-1:0] proc_addr;
        logic              finish;
    } t_ctrl;

    // Byte of a limit register for one level; bytes past the register read zero.
    function automatic logic [7:0] level_byte(input logic [CFG_W-1:0] r,
                                              input logic [LEVEL_W-1:0] lvl);
        logic [63:0] w;
        w = {{(64-CFG_W){1'b0}}, r};
        return w[{lvl, 3'b000} +: 8];
    endfunction

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

endpackage

[src/mlfq_ram.sv]
// ----------------------------------------------------------------------------
// mlfq_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module mlfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/mlfq_ctrl.sv]
// ----------------------------------------------------------------------------
// mlfq_ctrl: command sequencer of the MLFQ scheduler
// Walks the slot table one read per cycle and steps the datapath.
// ----------------------------------------------------------------------------
module mlfq_ctrl
    import mlfq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_command,
    input  logic [SLOT_W-1:0] i_slot,
    input  logic [2:0]  i_new_state,
    output logic        o_valid,
    input  logic        i_ready,
    output t_ctrl       o_ctrl
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SWEEP  = 3'd1;
    localparam logic [2:0] S_DRAIN  = 3'd2;
    localparam logic [2:0] S_FINISH = 3'd3;
    localparam logic [2:0] S_OUT    = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [SLOT_W-1:0] r_idx, n_idx;
    logic              r_pend, n_pend;
    logic [SLOT_W-1:0] r_pend_addr, n_pend_addr;
    logic [1:0]        r_cmd;
    logic [SLOT_W-1:0] r_slot;
    logic [2:0]        r_ns;
    logic              accept, last_rd;
    logic [SLOT_W-1:0] rd_addr;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign accept  = i_valid && o_ready;
    assign last_rd = (r_cmd == CMD_SET) || (r_idx == SLOT_W'(NUM_SLOTS - 1));
    assign rd_addr = (r_cmd == CMD_SET) ? r_slot : r_idx;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_pend      = 1'b0;
        n_pend_addr = r_pend_addr;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_SWEEP;
                    n_idx   = '0;
                end
            end
            S_SWEEP: begin
                n_pend      = 1'b1;
                n_pend_addr = rd_addr;
                n_idx       = r_idx + 1'b1;
                if (last_rd) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
        end
        r_idx       <= n_idx;
        r_pend_addr <= n_pend_addr;
        if (accept) begin
            r_cmd  <= i_command;
            r_slot <= i_slot;
            r_ns   <= i_new_state;
        end
    end

    always_comb begin
        o_ctrl.start     = accept;
        o_ctrl.cmd       = r_cmd;
        o_ctrl.new_state = r_ns;
        o_ctrl.rd_en     = (r_state == S_SWEEP);
        o_ctrl.rd_addr   = rd_addr;
        o_ctrl.proc      = r_pend;
        o_ctrl.proc_addr = r_pend_addr;
        o_ctrl.finish    = (r_state == S_FINISH);
    end

    // A slot read is always processed before the finishing step.
    a_no_pend_at_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH) |-> !r_pend)
        else $error("slot still in flight at finish");

    // An accepted item starts a table walk in the next cycle.
    a_accept_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_SWEEP))
        else $error("accepted item did not start a walk");

    // Processing only follows a read issued in the previous cycle.
    a_proc_follows_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> $past(r_state == S_SWEEP))
        else $error("processing without a preceding read");

endmodule

[src/mlfq_dp.sv]
// ----------------------------------------------------------------------------
// mlfq_dp: datapath of the MLFQ scheduler
// Slot table RAM, per-slot update logic, best-candidate tracking and results.
// ----------------------------------------------------------------------------
module mlfq_dp
    import mlfq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ctrl             i_ctrl,
    input  logic              i_cfg_we,
    input  logic              i_cfg_addr,
    input  logic [CFG_W-1:0]  i_cfg_data,
    output logic [1:0]        o_status,
    output logic [SLOT_W-1:0] o_chosen_slot,
    output logic [ID_W-1:0]   o_task_id,
    output logic [LEVEL_W-1:0] o_task_level
);

    logic [CFG_W-1:0]  r_aging, r_slice;
    logic [ID_W-1:0]   r_now, r_next_id;
    logic [NUM_SLOTS-1:0] r_valid;

    logic              r_found;
    logic [SLOT_W-1:0] r_best_addr;
    t_rec              r_best_rec;
    logic [KEY_W-1:0]  r_best_key;

    logic [1:0]        r_status;
    logic [SLOT_W-1:0] r_res_slot;
    logic [ID_W-1:0]   r_res_id;
    logic [LEVEL_W-1:0] r_res_lvl;

    logic [$bits(t_rec)-1:0] rd_data;
    t_rec              rec, upd;
    logic              proc_we;
    logic              take_best;
    logic [KEY_W-1:0]  key;
    logic              fin_we;
    t_rec              fin_rec;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    t_rec              wr_rec;

    mlfq_ram #(
        .WIDTH($bits(t_rec)),
        .DEPTH(NUM_SLOTS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (wr_en),
        .i_waddr(wr_addr),
        .i_wdata(wr_rec),
        .i_re   (i_ctrl.rd_en),
        .i_raddr(i_ctrl.rd_addr),
        .o_rdata(rd_data)
    );

    // Slots never written since reset read as an unused, zeroed record.
    assign rec = r_valid[i_ctrl.proc_addr] ? t_rec'(rd_data) : '0;
    assign key = {1'b0, upd.entry} + KEY_W'(upd.io_wait);

    always_comb begin
        upd       = rec;
        proc_we   = 1'b0;
        take_best = 1'b0;
        case (i_ctrl.cmd)
            CMD_TICK: begin
                proc_we = i_ctrl.proc;
                if (rec.state == ST_RUNNING) begin
                    upd.slice = sat_inc(rec.slice);
                end else if (rec.state == ST_RUNNABLE) begin
                    upd.wait_cnt = sat_inc(rec.wait_cnt);
                end else if (rec.state == ST_SLEEPING) begin
                    upd.io_wait  = sat_inc(rec.io_wait);
                    upd.wait_cnt = '0;
                end
            end
            CMD_ALLOC: begin
                take_best = i_ctrl.proc && !r_found && (rec.state == ST_UNUSED);
            end
            CMD_SET: begin
                if (rec.state != ST_UNUSED && i_ctrl.new_state <= ST_ZOMBIE) begin
                    proc_we   = i_ctrl.proc;
                    upd.state = i_ctrl.new_state;
                    if (rec.state == ST_RUNNING && i_ctrl.new_state != ST_RUNNING) begin
                        if (rec.slice >= COUNT_WIDTH'(level_byte(r_slice, rec.level)) &&
                            i_ctrl.new_state != ST_ZOMBIE &&
                            i_ctrl.new_state != ST_UNUSED && rec.id > ID_W'(2)) begin
                            upd.slice    = '0;
                            if (rec.level < LEVEL_W'(NUM_LEVELS - 1)) begin
                                upd.level = rec.level + 1'b1;
                            end
                            upd.entry    = r_now;
                            upd.wait_cnt = '0;
                        end else if (i_ctrl.new_state == ST_SLEEPING) begin
                            upd.slice    = '0;
                            upd.entry    = r_now;
                            upd.wait_cnt = '0;
                        end
                    end
                end
            end
            default: begin
                // Schedule: aging first, then candidate comparison on the aged slot.
                if (rec.state == ST_RUNNABLE && rec.level != '0 &&
                    rec.wait_cnt >= COUNT_WIDTH'(level_byte(r_aging, rec.level))) begin
                    proc_we      = i_ctrl.proc;
                    upd.level    = rec.level - 1'b1;
                    upd.slice    = '0;
                    upd.wait_cnt = '0;
                    upd.io_wait  = '0;
                    upd.entry    = r_now;
                end
                if (i_ctrl.proc && upd.state == ST_RUNNABLE) begin
                    take_best = !r_found || (upd.level < r_best_rec.level) ||
                                (upd.level == r_best_rec.level && key < r_best_key);
                end
            end
        endcase
    end

    always_comb begin
        fin_we  = 1'b0;
        fin_rec = r_best_rec;
        if (i_ctrl.finish && r_found) begin
            if (i_ctrl.cmd == CMD_ALLOC) begin
                fin_we        = 1'b1;
                fin_rec       = '0;
                fin_rec.state = ST_EMBRYO;
                fin_rec.entry = r_now;
                fin_rec.id    = r_next_id;
            end else if (i_ctrl.cmd == CMD_SCHED) begin
                fin_we           = 1'b1;
                fin_rec.state    = ST_RUNNING;
                fin_rec.wait_cnt = '0;
                fin_rec.io_wait  = '0;
            end
        end
    end

    assign wr_en   = proc_we || fin_we;
    assign wr_addr = fin_we ? r_best_addr : i_ctrl.proc_addr;
    assign wr_rec  = fin_we ? fin_rec : upd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_aging   <= AGING_RESET;
            r_slice   <= SLICE_RESET;
            r_now     <= '0;
            r_next_id <= ID_W'(1);
            r_valid   <= '0;
            r_found   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_addr == CFG_AGING) begin
                    r_aging <= i_cfg_data;
                end else begin
                    r_slice <= i_cfg_data;
                end
            end
            if (wr_en) begin
                r_valid[wr_addr] <= 1'b1;
            end
            if (i_ctrl.start) begin
                r_found <= 1'b0;
            end else if (take_best) begin
                r_found <= 1'b1;
            end
            if (i_ctrl.finish) begin
                if (i_ctrl.cmd == CMD_TICK) begin
                    r_now <= r_now + 1'b1;
                end
                if (i_ctrl.cmd == CMD_ALLOC && r_found) begin
                    r_next_id <= r_next_id + 1'b1;
                end
            end
        end
        if (take_best) begin
            r_best_addr <= i_ctrl.proc_addr;
            r_best_rec  <= upd;
            r_best_key  <= key;
        end
        if (i_ctrl.cmd == CMD_SET && i_ctrl.proc) begin
            if (rec.state == ST_UNUSED) begin
                r_status   <= STAT_UNUSED;
                r_res_slot <= '0;
                r_res_id   <= '0;
                r_res_lvl  <= '0;
            end else begin
                r_status   <= STAT_OK;
                r_res_slot <= i_ctrl.proc_addr;
                r_res_id   <= rec.id;
                r_res_lvl  <= upd.level;
            end
        end
        if (i_ctrl.finish) begin
            case (i_ctrl.cmd)
                CMD_TICK: begin
                    r_status   <= STAT_OK;
                    r_res_slot <= '0;
                    r_res_id   <= '0;
                    r_res_lvl  <= '0;
                end
                CMD_ALLOC: begin
                    r_status   <= r_found ? STAT_OK : STAT_NO_SLOT;
                    r_res_slot <= r_found ? r_best_addr : '0;
                    r_res_id   <= r_found ? r_next_id : '0;
                    r_res_lvl  <= '0;
                end
                CMD_SCHED: begin
                    r_status   <= r_found ? STAT_OK : STAT_NONE_RUN;
                    r_res_slot <= r_found ? r_best_addr : '0;
                    r_res_id   <= r_found ? r_best_rec.id : '0;
                    r_res_lvl  <= r_found ? r_best_rec.level : '0;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_status      = r_status;
    assign o_chosen_slot = r_res_slot;
    assign o_task_id     = r_res_id;
    assign o_task_level  = r_res_lvl;

    // The finishing write and a walk write never fall in the same cycle.
    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(proc_we && fin_we))
        else $error("two writers on the slot table");

endmodule

[src/mlfq_process_scheduler_core.sv]
// ----------------------------------------------------------------------------
// mlfq_process_scheduler_core: multilevel feedback queue scheduler with aging
// Top level: command sequencer plus slot-table datapath.
// ----------------------------------------------------------------------------
// The block keeps 64 task slots in one RAM and takes one command item at a
// time. Tick, alloc and schedule walk the slot table through the single RAM
// read port, one slot per cycle; their result is offered after the walk over
// all slots, a drain state and a finishing write. Set_state reads only its
// own slot. A new item is accepted only once the previous result has been
// taken, so a receiver that holds a result delays the next item. Slots that
// were never written since reset read as unused with zero counters, so no
// clearing pass is needed. The limit registers may be written whenever the
// block is idle.
module mlfq_process_scheduler_core
    import mlfq_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_command,
    input  logic [SLOT_W-1:0]  i_slot,
    input  logic [2:0]         i_new_state,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_status,
    output logic [SLOT_W-1:0]  o_chosen_slot,
    output logic [ID_W-1:0]    o_task_id,
    output logic [LEVEL_W-1:0] o_task_level,
    input  logic               i_cfg_we,
    input  logic               i_cfg_addr,
    input  logic [CFG_W-1:0]   i_cfg_data
);

    t_ctrl ctrl;

    // The sequencer owns both handshakes and the walk over the table.
    mlfq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_command  (i_command),
        .i_slot     (i_slot),
        .i_new_state(i_new_state),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_ctrl     (ctrl)
    );

    // The datapath updates slots as they stream by and holds the result.
    mlfq_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (ctrl),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .o_status     (o_status),
        .o_chosen_slot(o_chosen_slot),
        .o_task_id    (o_task_id),
        .o_task_level (o_task_level)
    );

endmodule
